@@ rtl/core/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Field widths, operation and status codes shared by the hash table files.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int TABLE_SIZE_DEFAULT = 32;

	localparam int KEY_W  = 31;
	localparam int VAL_W  = 16;
	localparam int SLOT_W = 5;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_INSERTED  = 2'd0,
		STATUS_FOUND     = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_FULL      = 2'd3
	} status_t;

endpackage

@@ rtl/core/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/lpht_hash.sv @@
// ----------------------------------------------------------------------------
// Home slot unit
// Three-stage key modulo table size by reciprocal multiply and correction.
// ----------------------------------------------------------------------------
module lpht_hash #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [lpht_pkg::KEY_W-1:0]    in_key,
	output logic                          out_valid,
	output logic [$clog2(TABLE_SIZE)-1:0] out_slot
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int KW = lpht_pkg::KEY_W;
	localparam logic [31:0] RECIP = 32'(33'h1_0000_0000 / TABLE_SIZE);
	localparam logic [KW-1:0] SIZE_K = KW'(TABLE_SIZE);

	logic              v_s1, v_s2, v_s3;
	logic [KW-1:0]     key_s1, key_s2;
	logic [KW+31:0]    prod_s1;
	logic [KW-1:0]     qn_s2;
	logic [AW-1:0]     slot_s3;

	logic [KW+31:0]    prod_c;
	logic [KW-1:0]     quot_c;
	logic [KW-1:0]     qn_c;
	logic [KW-1:0]     rem_c;
	logic [KW-1:0]     rem_adj_c;

	assign prod_c    = {32'b0, in_key} * {KW'(0), RECIP};
	assign quot_c    = prod_s1[KW+31:32];
	assign qn_c      = quot_c * SIZE_K;
	assign rem_c     = key_s2 - qn_s2;
	assign rem_adj_c = (rem_c >= SIZE_K) ? (rem_c - SIZE_K) : rem_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		key_s1  <= in_key;
		qn_s2   <= qn_c;
		key_s2  <= key_s1;
		slot_s3 <= AW'(rem_adj_c);
	end

	assign out_valid = v_s3;
	assign out_slot  = slot_s3;

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open addressing table of nonzero keys with insert and search requests.
// ----------------------------------------------------------------------------
// After reset the key memory is swept to empty with s_tready low. One request
// is handled at a time. A request with key zero goes straight to the result;
// any other request probes 1 to TABLE_SIZE slots: the modulo pipeline gives
// the home slot, then one key memory read per probe, pipelined at one probe
// per cycle. A result may wait in the output register while the next request
// is taken.
module linear_probe_hash_table #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // key[30:0], payload[46:31], zero[47]
	input  logic [0:0]  s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // payload_out[15:0], slot[20:16], zero[23:21]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int KW = lpht_pkg::KEY_W;
	localparam int VW = lpht_pkg::VAL_W;
	localparam int SW = lpht_pkg::SLOT_W;
	localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HASH  = 5'b00100,
		ST_PROBE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       chk_q;
	logic [AW-1:0]       cnt_q;
	logic                pend_q;
	lpht_pkg::opcode_t   op_q;
	logic [KW-1:0]       key_q;
	logic [VW-1:0]       val_q;
	lpht_pkg::status_t   res_status_q;
	logic [VW-1:0]       res_val_q;
	logic [SW-1:0]       res_slot_q;
	logic                out_valid_q;
	lpht_pkg::status_t   out_status_q;
	logic [VW-1:0]       out_val_q;
	logic [SW-1:0]       out_slot_q;

	logic                accept;
	logic [KW-1:0]       in_key;
	logic                hash_valid;
	logic [AW-1:0]       hash_slot;
	logic [KW-1:0]       key_rdata;
	logic [VW-1:0]       val_rdata;
	logic                key_we;
	logic [AW-1:0]       key_waddr;
	logic [KW-1:0]       key_wdata;
	logic                val_we;
	logic                hit_empty;
	logic                hit_match;
	logic                probe_end;
	logic                probe_done;
	logic                out_load;
	logic [AW-1:0]       addr_next;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_key   = s_tdata[KW-1:0];

	lpht_hash #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept && (in_key != '0)),
		.in_key   (in_key),
		.out_valid(hash_valid),
		.out_slot (hash_slot)
	);

	assign hit_empty  = pend_q && (key_rdata == '0);
	assign hit_match  = pend_q && (key_rdata == key_q);
	assign probe_end  = pend_q && (cnt_q == LAST);
	assign probe_done = (state_q == ST_PROBE) &&
		(hit_empty || (hit_match && (op_q == lpht_pkg::OP_SEARCH)) || probe_end);
	assign addr_next  = (addr_q == LAST) ? '0 : (addr_q + 1'b1);

	assign val_we    = (state_q == ST_PROBE) && hit_empty && (op_q == lpht_pkg::OP_INSERT);
	assign key_we    = (state_q == ST_CLEAR) || val_we;
	assign key_waddr = (state_q == ST_CLEAR) ? clr_q : chk_q;
	assign key_wdata = (state_q == ST_CLEAR) ? '0 : key_q;

	lpht_ram #(
		.WIDTH(KW),
		.DEPTH(TABLE_SIZE)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.raddr(addr_q),
		.rdata(key_rdata)
	);

	lpht_ram #(
		.WIDTH(VW),
		.DEPTH(TABLE_SIZE)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(chk_q),
		.wdata(val_q),
		.raddr(addr_q),
		.rdata(val_rdata)
	);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (in_key == '0) ? ST_DONE : ST_HASH;
					end
				end
				ST_HASH: begin
					pend_q <= 1'b0;
					cnt_q  <= '0;
					if (hash_valid) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					pend_q <= 1'b1;
					if (pend_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (probe_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= lpht_pkg::opcode_t'(s_tuser[0]);
			key_q <= in_key;
			val_q <= s_tdata[KW+VW-1:KW];
			res_status_q <= (s_tuser[0] == lpht_pkg::OP_INSERT) ?
				lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_NOT_FOUND;
			res_val_q  <= '0;
			res_slot_q <= '0;
		end
		if (state_q == ST_HASH) begin
			addr_q <= hash_slot;
		end
		if (state_q == ST_PROBE) begin
			addr_q <= addr_next;
			chk_q  <= addr_q;
			priority if (hit_empty && (op_q == lpht_pkg::OP_INSERT)) begin
				res_status_q <= lpht_pkg::STATUS_INSERTED;
				res_val_q    <= '0;
				res_slot_q   <= SW'(chk_q);
			end else if (hit_match && (op_q == lpht_pkg::OP_SEARCH)) begin
				res_status_q <= lpht_pkg::STATUS_FOUND;
				res_val_q    <= val_rdata;
				res_slot_q   <= SW'(chk_q);
			end else if (hit_empty || probe_end) begin
				res_status_q <= (op_q == lpht_pkg::OP_INSERT) ?
					lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_NOT_FOUND;
				res_val_q    <= '0;
				res_slot_q   <= '0;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_slot_q, out_val_q};
	assign m_tuser  = out_status_q;

endmodule

@@ rtl/core/lpht_checker.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Port-level assertions on requests and results, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in progress");

	a_value_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != lpht_pkg::STATUS_FOUND) |-> (m_tdata[15:0] == 16'd0))
		else $error("payload_out nonzero without a match");

	a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == lpht_pkg::STATUS_NOT_FOUND) ||
		(m_tuser == lpht_pkg::STATUS_FULL)) |-> (m_tdata[20:16] == 5'd0))
		else $error("slot nonzero on a miss");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
